/* design/playfair_digraph_cipher_assert.svh */
// assertion macros for the playfair digraph cipher
// the using module must provide clk and rst_n (asynchronous, active low)
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("playfair cipher check failed");

// next-cycle implication, checked out of reset
`define PLFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("playfair cipher check failed");

`endif

/* design/plfr_pkg.sv */
// shared types, constants and square helpers for the playfair digraph cipher
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package plfr_pkg;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;

    localparam int SIDE = 5;
    localparam int SQ_BITS = SIDE * SIDE * 5;
    typedef logic [SQ_BITS-1:0] square_t;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam coord_t  COORD_MAX = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_MODE       = 3'd0;
    localparam logic [2:0] CFG_SQ_FIRST   = 3'd1;
    localparam logic [2:0] CFG_SQ_MIDDLE  = 3'd2;
    localparam logic [2:0] CFG_SQ_LAST    = 3'd3;
    localparam logic [2:0] CFG_FILLER     = 3'd4;

    localparam letter_t FILLER_RESET = 5'd23;

    // one digraph job from the front to the back
    typedef struct packed {
        logic    odd;      // decrypt odd tail, no lookup
        logic    decrypt;  // shift left and up
        logic    last;     // second letter closes the message
        letter_t a;
        letter_t b;
    } job_t;

    typedef struct packed {
        coord_t row;
        coord_t col;
    } loc_t;

    function automatic letter_t fold_j(letter_t c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    // first matching cell in row-major order, row 0 column 0 when absent
    function automatic loc_t locate(square_t sq, letter_t code);
        loc_t res;
        res = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[(r * SIDE + c) * 5 +: 5] == code) begin
                    res.row = coord_t'(r);
                    res.col = coord_t'(c);
                end
            end
        end
        return res;
    endfunction

    function automatic letter_t cell_rc(square_t sq, coord_t row, coord_t col);
        letter_t res;
        res = '0;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (row == coord_t'(r) && col == coord_t'(c)) begin
                    res = sq[(r * SIDE + c) * 5 +: 5];
                end
            end
        end
        return res;
    endfunction

    // one step along a row or column with wrap
    function automatic coord_t step_coord(coord_t v, logic dec);
        coord_t res;
        if (dec) begin
            res = (v == 3'd0) ? COORD_MAX : v - 3'd1;
        end
        else begin
            res = (v == COORD_MAX) ? 3'd0 : v + 3'd1;
        end
        return res;
    endfunction

endpackage

/* design/plfr_front.sv */
// front end: folds letters, pairs them into digraphs, inserts filler
// depends on plfr_pkg; feeds jobs to plfr_queue
`timescale 1ns / 1ps

module plfr_front
    import plfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  letter_t in_letter,
    input  logic    in_last,
    input  logic    mode,
    input  letter_t filler,
    output logic    job_valid,
    input  logic    job_ready,
    output job_t    job_data
);

    logic    pend_valid_reg, pend_valid_next;
    letter_t pend_code_reg, pend_code_next;
    logic [1:0] count_reg, count_next;
    job_t    slot0_reg, slot0_next;
    job_t    slot1_reg, slot1_next;

    letter_t l;
    letter_t fill;
    job_t    j0;
    job_t    j1;
    logic [1:0] n_jobs;
    logic    new_pend_valid;
    letter_t new_pend_code;
    logic    accept;
    logic    push;

    // classify the incoming letter
    always_comb
    begin
        l = fold_j(in_letter);
        fill = fold_j(filler);
        j0 = '0;
        j1 = '0;
        n_jobs = 2'd0;
        new_pend_valid = pend_valid_reg;
        new_pend_code = pend_code_reg;
        if (mode) begin
            if (pend_valid_reg) begin
                j0.decrypt = 1'b1;
                j0.last = in_last;
                j0.a = pend_code_reg;
                j0.b = l;
                n_jobs = 2'd1;
                new_pend_valid = 1'b0;
                new_pend_code = '0;
            end
            else if (in_last) begin
                j0.odd = 1'b1;
                j0.decrypt = 1'b1;
                j0.last = 1'b1;
                n_jobs = 2'd1;
            end
            else begin
                new_pend_valid = 1'b1;
                new_pend_code = l;
            end
        end
        else if (pend_valid_reg && pend_code_reg != l) begin
            j0.last = in_last;
            j0.a = pend_code_reg;
            j0.b = l;
            n_jobs = 2'd1;
            new_pend_valid = 1'b0;
            new_pend_code = '0;
        end
        else if (pend_valid_reg) begin
            // doubled letter: close with filler, then hold or pad the new one
            j0.a = pend_code_reg;
            j0.b = fill;
            if (in_last) begin
                j1.last = 1'b1;
                j1.a = l;
                j1.b = fill;
                n_jobs = 2'd2;
                new_pend_valid = 1'b0;
                new_pend_code = '0;
            end
            else begin
                n_jobs = 2'd1;
                new_pend_code = l;
            end
        end
        else if (in_last) begin
            j0.last = 1'b1;
            j0.a = l;
            j0.b = fill;
            n_jobs = 2'd1;
        end
        else begin
            new_pend_valid = 1'b1;
            new_pend_code = l;
        end
    end

    // handshakes
    assign job_valid = (count_reg != 2'd0);
    assign job_data  = slot0_reg;
    assign push      = job_valid && job_ready;
    assign in_ready  = (count_reg == 2'd0) || (count_reg == 2'd1 && job_ready);
    assign accept    = in_valid && in_ready;

    // job slots and pairing state
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next = pend_code_reg;
        if (accept) begin
            slot0_next = j0;
            slot1_next = j1;
            count_next = n_jobs;
            pend_valid_next = new_pend_valid;
            pend_code_next = new_pend_code;
        end
        else if (push) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= 2'd0;
            pend_valid_reg <= 1'b0;
            pend_code_reg <= '0;
        end
        else begin
            count_reg <= count_next;
            pend_valid_reg <= pend_valid_next;
            pend_code_reg <= pend_code_next;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* design/plfr_queue.sv */
// short job queue between the front and the back ends
// depends on plfr_pkg for the job type
`timescale 1ns / 1ps

module plfr_queue
    import plfr_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/plfr_back.sv */
// back end: locates a digraph in the key square, substitutes, emits letters
// depends on plfr_pkg; takes jobs from plfr_queue
`timescale 1ns / 1ps

module plfr_back
    import plfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  square_t square,
    input  logic    job_valid,
    output logic    job_ready,
    input  job_t    job_data,
    output logic    out_valid,
    input  logic    out_ready,
    output letter_t out_letter,
    output logic    out_last,
    output logic    odd_error
);

    logic    s1_valid_reg, s1_valid_next;
    job_t    s1_job_reg;
    loc_t    s1_loca_reg;
    loc_t    s1_locb_reg;

    logic    out_valid_reg, out_valid_next;
    logic    second_reg, second_next;
    letter_t x_reg;
    letter_t y_reg;
    logic    last_reg;
    logic    odd_reg;

    logic    s1_load;
    logic    s2_load;
    logic    beat;
    logic    done_beat;
    letter_t x;
    letter_t y;

    // stage handoff
    assign beat      = out_valid_reg && out_ready;
    assign done_beat = beat && (odd_reg || second_reg);
    assign s2_load   = s1_valid_reg && (!out_valid_reg || done_beat);
    assign job_ready = !s1_valid_reg || s2_load;
    assign s1_load   = job_valid && job_ready;

    // substitution rules on the located pair
    always_comb
    begin
        x = '0;
        y = '0;
        if (s1_job_reg.odd) begin
            x = '0;
            y = '0;
        end
        else if (s1_loca_reg.row == s1_locb_reg.row) begin
            x = cell_rc(square, s1_loca_reg.row,
                        step_coord(s1_loca_reg.col, s1_job_reg.decrypt));
            y = cell_rc(square, s1_locb_reg.row,
                        step_coord(s1_locb_reg.col, s1_job_reg.decrypt));
        end
        else if (s1_loca_reg.col == s1_locb_reg.col) begin
            x = cell_rc(square, step_coord(s1_loca_reg.row, s1_job_reg.decrypt),
                        s1_loca_reg.col);
            y = cell_rc(square, step_coord(s1_locb_reg.row, s1_job_reg.decrypt),
                        s1_locb_reg.col);
        end
        else begin
            x = cell_rc(square, s1_loca_reg.row, s1_locb_reg.col);
            y = cell_rc(square, s1_locb_reg.row, s1_loca_reg.col);
        end
    end

    // control next state
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        out_valid_next = out_valid_reg;
        second_next = second_reg;
        if (s1_load) begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load) begin
            s1_valid_next = 1'b0;
        end
        if (s2_load) begin
            out_valid_next = 1'b1;
            second_next = 1'b0;
        end
        else if (done_beat) begin
            out_valid_next = 1'b0;
            second_next = 1'b0;
        end
        else if (beat) begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            second_reg <= second_next;
        end
    end

    // locate stage and output stage payload
    always_ff @(posedge clk)
    begin
        if (s1_load) begin
            s1_job_reg <= job_data;
            s1_loca_reg <= locate(square, job_data.a);
            s1_locb_reg <= locate(square, job_data.b);
        end
        if (s2_load) begin
            x_reg <= x;
            y_reg <= y;
            last_reg <= s1_job_reg.last;
            odd_reg <= s1_job_reg.odd;
        end
    end

    // output beat select
    assign out_valid  = out_valid_reg;
    assign out_letter = second_reg ? y_reg : x_reg;
    assign out_last   = odd_reg || (second_reg && last_reg);
    assign odd_error  = odd_reg;

endmodule

/* design/playfair_digraph_cipher.sv */
// a result beat is registered in the front slot, the job queue, the locate stage
// and the output stage; a letter is taken every cycle while the job queue has room,
// except the cycle after a doubled final letter in encrypt; the back end sends one
// letter a beat: a digraph gives two output beats, a doubled final letter four
// reset: rst_n asynchronous active low clears pairing state, queue and config
// (filler resets to 'x', square to all zeros, mode to encrypt)
`timescale 1ns / 1ps

`include "playfair_digraph_cipher_assert.svh"

module playfair_digraph_cipher
    import plfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [4:0] letter, [7:5] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // [4:0] out_letter, [7:5] zero
    output logic        m_tlast,
    output logic        m_tuser,     // [0] odd_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [49:0] cfg_data
);

    logic        mode_reg;
    logic [49:0] sq_first_reg;
    logic [49:0] sq_middle_reg;
    logic [24:0] sq_last_reg;
    letter_t     filler_reg;

    logic    q_push_valid;
    logic    q_push_ready;
    job_t    q_push_data;
    logic    q_pop_valid;
    logic    q_pop_ready;
    job_t    q_pop_data;
    letter_t out_letter;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= 1'b0;
            sq_first_reg <= '0;
            sq_middle_reg <= '0;
            sq_last_reg <= '0;
            filler_reg <= FILLER_RESET;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MODE:      mode_reg <= cfg_data[0];
                CFG_SQ_FIRST:  sq_first_reg <= cfg_data;
                CFG_SQ_MIDDLE: sq_middle_reg <= cfg_data;
                CFG_SQ_LAST:   sq_last_reg <= cfg_data[24:0];
                CFG_FILLER:    filler_reg <= cfg_data[4:0];
                default:       ;
            endcase
        end
    end

    // pairing front end
    plfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_letter (s_tdata[4:0]),
        .in_last   (s_tlast),
        .mode      (mode_reg),
        .filler    (filler_reg),
        .job_valid (q_push_valid),
        .job_ready (q_push_ready),
        .job_data  (q_push_data)
    );

    // digraph job queue
    plfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // substitution back end
    plfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .square     ({sq_last_reg, sq_middle_reg, sq_first_reg}),
        .job_valid  (q_pop_valid),
        .job_ready  (q_pop_ready),
        .job_data   (q_pop_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_letter (out_letter),
        .out_last   (m_tlast),
        .odd_error  (m_tuser)
    );

    assign m_tdata = {3'b000, out_letter};

    // checks
    `PLFR_ASSERT_NOW(a_odd_beat_closes, m_tvalid && m_tuser, m_tlast && m_tdata == 8'd0)
    `PLFR_ASSERT_NOW(a_odd_only_decrypt, m_tvalid && m_tuser, mode_reg)
    `PLFR_ASSERT_NEXT(a_front_holds_job, q_push_valid && !q_push_ready,
                      q_push_valid && $stable(q_push_data))

endmodule

/* tb/tb_playfair_digraph_cipher.sv */
// self-checking testbench for the playfair digraph cipher stream block
// depends on plfr_pkg and playfair_digraph_cipher; keeps its own cipher predictor
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;
    import plfr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PCT      = 30;
    localparam int HOLD_CYCLES   = 120;

    localparam logic       MODE_ENCRYPT  = 1'b0;
    localparam logic       MODE_DECRYPT  = 1'b1;
    localparam logic [2:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        letter_t letter;
        logic    is_last;
        logic    odd_error;
    } cipher_beat_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [49:0] cfg_data  = '0;

    // predictor copy of the configuration and pairing state
    logic        pred_decrypt   = MODE_ENCRYPT;
    logic [49:0] pred_sq_first  = '0;
    logic [49:0] pred_sq_middle = '0;
    logic [24:0] pred_sq_last   = '0;
    letter_t     pred_filler    = FILLER_RESET;
    logic        held_valid     = 1'b0;
    letter_t     held_letter    = '0;

    cipher_beat_t subst_due[$];
    cipher_beat_t due_beat;
    int           fail_count  = 0;
    int           cycle_count = 0;
    bit           tx_idle_en  = 1'b1;
    bit           rx_stall_en = 1'b1;
    int           rx_hold_len = 0;

    playfair_digraph_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // ---------------- predictor ----------------

    function automatic letter_t fold_ji(letter_t c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

    function automatic letter_t key_cell(int row, int col);
        square_t sq;
        sq = {pred_sq_last, pred_sq_middle, pred_sq_first};
        return sq[(row * SIDE + col) * 5 +: 5];
    endfunction

    // add one expected beat at the tail
    function automatic void due_append(cipher_beat_t b);
        subst_due = {subst_due, b};
    endfunction

    // first hit in row-major order, top-left corner when missing
    function automatic void find_letter(letter_t code, output int row, output int col);
        bit found;
        found = 1'b0;
        row = 0;
        col = 0;
        for (int k = 0; k < SIDE * SIDE; k++) begin
            if (!found && key_cell(k / SIDE, k % SIDE) == code) begin
                found = 1'b1;
                row = k / SIDE;
                col = k % SIDE;
            end
        end
    endfunction

    // substitute one digraph and queue its two beats
    function automatic void substitute_pair(letter_t a, letter_t b, logic lst);
        int ra, ca, rb, cb, step;
        letter_t x, y;
        step = pred_decrypt ? SIDE - 1 : 1;
        find_letter(a, ra, ca);
        find_letter(b, rb, cb);
        if (ra == rb) begin
            x = key_cell(ra, (ca + step) % SIDE);
            y = key_cell(rb, (cb + step) % SIDE);
        end
        else if (ca == cb) begin
            x = key_cell((ra + step) % SIDE, ca);
            y = key_cell((rb + step) % SIDE, cb);
        end
        else begin
            x = key_cell(ra, cb);
            y = key_cell(rb, ca);
        end
        due_append(cipher_beat_t'{x, 1'b0, 1'b0});
        due_append(cipher_beat_t'{y, lst, 1'b0});
    endfunction

    // pairing rules for one accepted letter
    function automatic void pair_and_substitute(letter_t raw, logic lst);
        letter_t l, fill;
        l = fold_ji(raw);
        fill = fold_ji(pred_filler);
        if (pred_decrypt) begin
            if (held_valid) begin
                substitute_pair(held_letter, l, lst);
                held_valid = 1'b0;
            end
            else if (lst) begin
                due_append(cipher_beat_t'{letter_t'(0), 1'b1, 1'b1});
            end
            else begin
                held_valid = 1'b1;
                held_letter = l;
            end
        end
        else if (held_valid && held_letter != l) begin
            substitute_pair(held_letter, l, lst);
            held_valid = 1'b0;
        end
        else begin
            // doubled letter closes the held one with the filler
            if (held_valid) begin
                substitute_pair(held_letter, fill, 1'b0);
            end
            if (lst) begin
                substitute_pair(l, fill, 1'b1);
                held_valid = 1'b0;
            end
            else begin
                held_valid = 1'b1;
                held_letter = l;
            end
        end
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [49:0] value);
        case (idx)
            CFG_MODE:      pred_decrypt   = value[0];
            CFG_SQ_FIRST:  pred_sq_first  = value;
            CFG_SQ_MIDDLE: pred_sq_middle = value;
            CFG_SQ_LAST:   pred_sq_last   = value[24:0];
            CFG_FILLER:    pred_filler    = value[4:0];
            default:       ;
        endcase
    endfunction

    // ---------------- squares and letters ----------------

    // alphabet without j, optionally shuffled
    function automatic square_t key_square(bit shuffle);
        letter_t cells[SIDE * SIDE];
        letter_t t;
        square_t sq;
        int k, j;
        k = 0;
        for (int c = 0; c < 26; c++) begin
            if (c != LETTER_J) begin
                cells[k] = letter_t'(c);
                k++;
            end
        end
        if (shuffle) begin
            for (int i = SIDE * SIDE - 1; i > 0; i--) begin
                j = $urandom_range(i);
                t = cells[i];
                cells[i] = cells[j];
                cells[j] = t;
            end
        end
        for (int i = 0; i < SIDE * SIDE; i++) begin
            sq[i * 5 +: 5] = cells[i];
        end
        return sq;
    endfunction

    // mostly plain letters, some doubles, the filler and codes past z
    function automatic letter_t random_letter(letter_t prev, bit has_prev);
        int pick;
        pick = $urandom_range(99);
        if (has_prev && pick < 20) begin
            return prev;
        end
        if (pick < 25) begin
            return pred_filler;
        end
        if (pick < 31) begin
            return letter_t'($urandom_range(31, 26));
        end
        return letter_t'($urandom_range(25));
    endfunction

    // ---------------- drivers ----------------

    task automatic send_letter(letter_t code, logic lst);
        bit taken;
        if (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, code};
        s_tlast  <= lst;
        do begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end while (!taken);
        pair_and_substitute(code, lst);
    endtask

    task automatic send_run(letter_t codes[$]);
        foreach (codes[i]) begin
            send_letter(codes[i], i == codes.size() - 1);
        end
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic write_reg(logic [2:0] idx, logic [49:0] value);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        apply_reg(idx, value);
    endtask

    // all due beats out, then room for a held letter still in flight
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (subst_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic mode, square_t sq, letter_t fill);
        wait_idle();
        write_reg(CFG_MODE, 50'(mode));
        write_reg(CFG_SQ_FIRST, sq[49:0]);
        write_reg(CFG_SQ_MIDDLE, sq[99:50]);
        write_reg(CFG_SQ_LAST, 50'(sq[124:100]));
        write_reg(CFG_FILLER, 50'(fill));
        cfg_valid <= 1'b0;
    endtask

    // ---------------- tests ----------------

    // zero square from reset: every lookup lands top left
    task automatic test_reset_defaults();
        letter_t run[$];
        run = {5'd31, 5'd0};
        send_run(run);
    endtask

    // alphabet square: row, column, rectangle, doubles, j folding, odd tail
    task automatic test_encrypt_rules();
        letter_t run[$];
        configure(MODE_ENCRYPT, key_square(1'b0), FILLER_RESET);
        run = {5'd0, 5'd1, 5'd0, 5'd11, 5'd3, 5'd21};
        send_run(run);
        run = {5'd4, 5'd4, 5'd23};
        send_run(run);
        run = {5'd9, 5'd8};
        send_run(run);
        // held filler meets the filler
        run = {5'd23, 5'd23};
        send_run(run);
        // filler j folds to i
        configure(MODE_ENCRYPT, key_square(1'b0), LETTER_J);
        run = {5'd7};
        send_run(run);
    endtask

    task automatic test_decrypt_rules();
        letter_t run[$];
        configure(MODE_DECRYPT, key_square(1'b0), FILLER_RESET);
        run = {5'd0, 5'd1, 5'd0, 5'd11, 5'd6, 5'd6, 5'd25};
        send_run(run);
    endtask

    // held letter survives a mode write, decrypt applies to the pair
    task automatic test_mode_switch();
        configure(MODE_ENCRYPT, key_square(1'b0), FILLER_RESET);
        send_letter(5'd0, 1'b0);
        wait_idle();
        write_reg(CFG_MODE, 50'(MODE_DECRYPT));
        cfg_valid <= 1'b0;
        send_letter(5'd1, 1'b1);
    endtask

    // all-ones square with a duplicated letter
    task automatic test_odd_square();
        letter_t run[$];
        square_t sq;
        sq = '1;
        sq[12 * 5 +: 5] = 5'd5;
        sq[18 * 5 +: 5] = 5'd5;
        configure(MODE_ENCRYPT, sq, FILLER_RESET);
        run = {5'd5, 5'd31};
        send_run(run);
    endtask

    // writes past the last register must not touch anything
    task automatic test_unused_index();
        letter_t run[$];
        configure(MODE_ENCRYPT, key_square(1'b0), FILLER_RESET);
        @(posedge clk);
        for (int i = CFG_UNUSED_LO; i <= CFG_UNUSED_HI; i++) begin
            write_reg(3'(i), '1);
        end
        cfg_valid <= 1'b0;
        run = {5'd2, 5'd9};
        send_run(run);
    endtask

    task automatic test_random_messages();
        letter_t codes[$];
        square_t sq;
        letter_t fill;
        int sent, len, pick;
        for (int phase = 0; phase < 8; phase++) begin
            // one phase runs with no idling on either side
            tx_idle_en = (phase != 3);
            rx_stall_en = (phase != 3);
            pick = $urandom_range(99);
            sq = key_square(1'b1);
            if (pick < 15) begin
                sq = square_t'({$urandom, $urandom, $urandom, $urandom});
            end
            else if (pick < 30) begin
                for (int i = 0; i < 3; i++) begin
                    sq[$urandom_range(SIDE * SIDE - 1) * 5 +: 5] = letter_t'($urandom_range(31));
                end
            end
            fill = (phase == 1) ? letter_t'(0) :
                   (phase == 2) ? letter_t'(31) : letter_t'($urandom_range(25));
            configure(logic'(phase % 2), sq, fill);
            sent = 0;
            while (sent < 16) begin
                codes.delete();
                len = $urandom_range(10, 1);
                for (int i = 0; i < len; i++) begin
                    codes = {codes, random_letter(i > 0 ? codes[$] : letter_t'(0), i > 0)};
                end
                send_run(codes);
                sent += len;
            end
        end
        tx_idle_en = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // receiver stops long enough for the job queue to fill and stall input
    task automatic test_output_backpressure();
        letter_t codes[$];
        configure(MODE_ENCRYPT, key_square(1'b1), FILLER_RESET);
        tx_idle_en = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        for (int i = 0; i < 40; i++) begin
            codes = {codes, random_letter(i > 0 ? codes[$] : letter_t'(0), i > 0)};
        end
        send_run(codes);
        tx_idle_en = 1'b1;
    endtask

    // ---------------- receiver ----------------

    initial begin : receiver
        int hold;
        forever begin
            @(posedge clk);
            if (rx_hold_len > 0) begin
                hold = rx_hold_len;
                rx_hold_len = 0;
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            else if (rx_stall_en && $urandom_range(99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------- result check ----------------

    // a beat seen here is taken at the next rising edge
    always @(negedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (subst_due.size() == 0) begin
                $error("unexpected output beat: out_letter %0d", m_tdata[4:0]);
                fail_count++;
            end
            else begin
                due_beat = subst_due.pop_front();
                if (m_tdata[4:0] !== due_beat.letter) begin
                    $error("out_letter: expected %0d, got %0d", due_beat.letter, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tlast !== due_beat.is_last) begin
                    $error("out_last: expected %0b, got %0b", due_beat.is_last, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== due_beat.odd_error) begin
                    $error("odd_error: expected %0b, got %0b", due_beat.odd_error, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_encrypt_rules();
        test_decrypt_rules();
        test_mode_switch();
        test_odd_square();
        test_unused_index();
        test_random_messages();
        test_output_backpressure();
        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end
        else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
